FILE: rtl/dine_pkg.sv
// shared constants, types and neighbor ring tables for the depth image normal block
package dine_pkg;

   // field and register widths
   localparam int CFG_W         = 11;
   localparam int COORD_W       = 20;
   localparam int POINT_W       = 3 * COORD_W;
   localparam int ROW_W         = 11;
   localparam int NORMAL_W      = 16;
   localparam int PIX_W         = 10;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 4;
   localparam int REQ_DATA_W    = 64;
   localparam int RSP_DATA_W    = 72;

   // geometry limits
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_HEIGHT    = 1024;

   // register reset values
   localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;
   localparam logic             NEIGHBOR_MODE_RST = 1'b1;

   // register indexes
   localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_NEIGHBOR_MODE = 2'd2;

   // last ring position for each neighbor mode
   localparam logic [2:0] RING8_LAST = 3'd7;
   localparam logic [2:0] RING4_LAST = 3'd3;

   // unit scale shifts: pair vectors are q1.16, the output is q1.14
   localparam int PAIR_SH = 16;
   localparam int OUT_SH  = 14;

   // window position: row 0 is the upper row, col 0 the left column
   typedef struct packed {
      logic [1:0] row;
      logic [1:0] col;
   } offset_type;

   // ring position to window position, clockwise from upper left or up
   function automatic offset_type ring_offset(input logic mode, input logic [2:0] idx);
      offset_type off;
      off = '{row: 2'd1, col: 2'd1};
      if (mode) begin
         case (idx)
            3'd0: off = '{row: 2'd0, col: 2'd0};
            3'd1: off = '{row: 2'd0, col: 2'd1};
            3'd2: off = '{row: 2'd0, col: 2'd2};
            3'd3: off = '{row: 2'd1, col: 2'd2};
            3'd4: off = '{row: 2'd2, col: 2'd2};
            3'd5: off = '{row: 2'd2, col: 2'd1};
            3'd6: off = '{row: 2'd2, col: 2'd0};
            default: off = '{row: 2'd1, col: 2'd0};
         endcase
      end else begin
         case (idx)
            3'd0: off = '{row: 2'd0, col: 2'd1};
            3'd1: off = '{row: 2'd1, col: 2'd2};
            3'd2: off = '{row: 2'd2, col: 2'd1};
            3'd3: off = '{row: 2'd1, col: 2'd0};
            default: off = '{row: 2'd1, col: 2'd1};
         endcase
      end
      return off;
   endfunction

endpackage

FILE: rtl/depth_image_normal_estimation.sv
// top level: streaming surface normal estimation over an organized point image
//
// channel   dir   handshake                 payload
// req       in    req_tvalid / req_tready   tdata point x,y,z; tuser pad
// rsp       out   rsp_tvalid / rsp_tready   tdata normal x,y,z, column, row; tuser valid; tlast
// csr       in    psel / penable / pready   frame_width, frame_height, neighbor_mode
//
// a request that produces no result passes through the line store read, then the window shift
// a request that produces a result also gathers the ring, works through each counted
// ring pair and normalizes the sum; the bit-serial square root (25 steps) and the shared
// divider (19 steps per component) serve each counted pair and the normalization
// a finished result waits in the output register while the next request is taken
// line stores are not cleared after reset; entries never written are only read for
// pixels outside the frame
module depth_image_normal_estimation #(
   parameter int MAX_WIDTH = dine_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dine_pkg::REQ_DATA_W-1:0] req_tdata,  // point_x, point_y, point_z, zero fill
   input  logic                            req_tuser,  // pad
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dine_pkg::RSP_DATA_W-1:0] rsp_tdata,  // normal_x/y/z, column, row, zero fill
   output logic                            rsp_tuser,  // normal_valid
   output logic                            rsp_tlast,  // frame_last
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dine_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dine_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dine_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WCMP  = (CW + 1 > dine_pkg::CFG_W) ? CW + 1 : dine_pkg::CFG_W;
   localparam int PW    = dine_pkg::POINT_W;
   localparam int XW    = dine_pkg::COORD_W;
   localparam int RW    = dine_pkg::ROW_W;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SHIFT = 4'd1;
   localparam logic [3:0] S_RING  = 4'd2;
   localparam logic [3:0] S_PAIR  = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_ABS   = 4'd5;
   localparam logic [3:0] S_MAG   = 4'd6;
   localparam logic [3:0] S_SQ    = 4'd7;
   localparam logic [3:0] S_SQRT  = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_ACC   = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;

   // configuration
   logic [dine_pkg::CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [dine_pkg::CFG_W-1:0] frame_height_ff, frame_height_in;
   logic                       neighbor_mode_ff, neighbor_mode_in;

   // position counters and sequencer
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [3:0]    state_ff, state_in;

   // request point and 3x3 window
   logic [PW-1:0] point_ff, point_in;
   logic [PW-1:0] win_ff [3][3];
   logic [PW-1:0] win_in [3][3];

   // center pixel of the current result
   logic [CW-1:0] c_ff, c_in;
   logic [RW-1:0] rr_ff, rr_in;
   logic          last_ff, last_in;

   // neighbor ring, rotated one place per pair
   logic [PW-1:0] ring_ff [8];
   logic [PW-1:0] ring_in [8];
   logic [7:0]    ring_ok_ff, ring_ok_in;
   logic [2:0]    n_ff, n_in;

   // cross product
   logic signed [XW:0]   a_ff [3];
   logic signed [XW:0]   a_in [3];
   logic signed [XW:0]   b_ff [3];
   logic signed [XW:0]   b_in [3];
   logic [2:0]           mi_ff, mi_in;
   logic signed [49:0]   prod_ff, prod_in;
   logic signed [42:0]   v_ff [3];
   logic signed [42:0]   v_in [3];

   // vector normalization
   logic [42:0]   m_ff [3];
   logic [42:0]   m_in [3];
   logic [2:0]    neg_ff, neg_in;
   logic          final_ff, final_in;
   logic [1:0]    si_ff, si_in;
   logic [49:0]   sq_ff, sq_in;
   logic [49:0]   rad_ff, rad_in;
   logic [24:0]   root_ff, root_in;
   logic [26:0]   srem_ff, srem_in;
   logic [4:0]    it_ff, it_in;
   logic [1:0]    ci_ff, ci_in;
   logic [4:0]    dstep_ff, dstep_in;
   logic [25:0]   drem_ff, drem_in;
   logic [17:0]   dlow_ff, dlow_in;
   logic [17:0]   q_ff, q_in;
   logic signed [17:0] u_ff [3];
   logic signed [17:0] u_in [3];
   logic signed [20:0] sum_ff [3];
   logic signed [20:0] sum_in [3];

   // pending result and output register
   logic [dine_pkg::NORMAL_W-1:0] res_ff [3];
   logic [dine_pkg::NORMAL_W-1:0] res_in [3];
   logic                          res_valid_ff, res_valid_in;
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [dine_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                          rsp_tuser_ff, rsp_tuser_in;
   logic                          rsp_tlast_ff, rsp_tlast_in;

   // combinational helpers
   logic [WCMP-1:0] eff_w;
   logic [RW-1:0]   eff_h;
   logic [WCMP-1:0] col_w;
   logic [CW-1:0]   k_eff;
   logic [WCMP-1:0] k_w;
   logic [RW:0]     row_x;
   logic [RW:0]     h_x;
   logic [PW-1:0]   up_rd;
   logic [PW-1:0]   mid_rd;
   logic            mem_we;
   logic            csr_wr;
   logic [1:0]      csr_idx;
   logic [PW-1:0]   ctr;
   logic            ctr_ok;
   logic [PW-1:0]   ring_pt [8];
   logic [7:0]      ring_pt_ok;
   logic [WCMP-1:0] c_w;
   logic            ok_left, ok_right, ok_up, ok_down;
   logic [2:0]      ring_last;
   logic            do_adv;
   logic signed [24:0] opa, opb;
   logic [2:0]      pm;
   logic [28:0]     sq_t, sq_trial;
   logic [41:0]     num;
   logic [26:0]     dv_t, dv_den;
   logic            dv_ge;
   logic [17:0]     q_new;
   logic [WCMP-1:0] c_out_w;

   // effective geometry: zero acts as one, large values saturate
   always_comb begin
      if (frame_width_ff == '0) begin
         eff_w = WCMP'(1);
      end else if (WCMP'(frame_width_ff) > WCMP'(MAX_WIDTH)) begin
         eff_w = WCMP'(MAX_WIDTH);
      end else begin
         eff_w = WCMP'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         eff_h = RW'(1);
      end else if (frame_height_ff > RW'(dine_pkg::MAX_HEIGHT)) begin
         eff_h = RW'(dine_pkg::MAX_HEIGHT);
      end else begin
         eff_h = frame_height_ff;
      end
   end

   assign col_w = WCMP'(col_ff);
   assign k_eff = (col_w >= eff_w) ? '0 : col_ff;
   assign k_w   = WCMP'(k_eff);
   assign row_x = {1'b0, row_ff};
   assign h_x   = {1'b0, eff_h};

   // line stores: upper holds two rows back, middle one row back
   dine_ram #(.DATA_W(PW), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (k_eff),
      .wr_data (mid_rd),
      .rd_addr (k_eff),
      .rd_data (up_rd)
   );

   dine_ram #(.DATA_W(PW), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (k_eff),
      .wr_data (point_ff),
      .rd_addr (k_eff),
      .rd_data (mid_rd)
   );

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[dine_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      unique case (csr_idx)
         dine_pkg::REG_FRAME_WIDTH:   csr_prdata = dine_pkg::CSR_DATA_W'(frame_width_ff);
         dine_pkg::REG_FRAME_HEIGHT:  csr_prdata = dine_pkg::CSR_DATA_W'(frame_height_ff);
         dine_pkg::REG_NEIGHBOR_MODE: csr_prdata = dine_pkg::CSR_DATA_W'(neighbor_mode_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // center and ring gathering from the window, with frame bounds
   assign ctr     = win_ff[1][1];
   assign ctr_ok  = !ctr[PW-1] && (ctr[PW-1:2*XW] != '0);
   assign c_w     = WCMP'(c_ff);
   assign ok_left  = (c_ff != '0);
   assign ok_right = (c_w + WCMP'(1) < eff_w);
   assign ok_up    = (rr_ff != '0);
   assign ok_down  = ({1'b0, rr_ff} + (RW+1)'(1) < h_x);
   assign ring_last = neighbor_mode_ff ? dine_pkg::RING8_LAST : dine_pkg::RING4_LAST;

   always_comb begin
      dine_pkg::offset_type off;
      for (int j = 0; j < 8; j++) begin
         off = dine_pkg::ring_offset(neighbor_mode_ff, 3'(j));
         ring_pt[j] = win_ff[off.row][off.col];
         ring_pt_ok[j] = !ring_pt[j][PW-1] && (ring_pt[j][PW-1:2*XW] != '0)
                         && !(off.col == 2'd0 && !ok_left)
                         && !(off.col == 2'd2 && !ok_right)
                         && !(off.row == 2'd0 && !ok_up)
                         && !(off.row == 2'd2 && !ok_down);
      end
   end

   // shared multiplier operands
   assign pm = mi_ff - 3'd1;

   always_comb begin
      opa = '0;
      opb = '0;
      if (state_ff == S_MUL) begin
         case (mi_ff)
            3'd0: begin opa = 25'(b_ff[1]); opb = 25'(a_ff[2]); end
            3'd1: begin opa = 25'(b_ff[2]); opb = 25'(a_ff[1]); end
            3'd2: begin opa = 25'(b_ff[2]); opb = 25'(a_ff[0]); end
            3'd3: begin opa = 25'(b_ff[0]); opb = 25'(a_ff[2]); end
            3'd4: begin opa = 25'(b_ff[0]); opb = 25'(a_ff[1]); end
            3'd5: begin opa = 25'(b_ff[1]); opb = 25'(a_ff[0]); end
            default: begin opa = '0; opb = '0; end
         endcase
      end else if (state_ff == S_SQ && si_ff != 2'd3) begin
         opa = signed'({1'b0, m_ff[si_ff][23:0]});
         opb = signed'({1'b0, m_ff[si_ff][23:0]});
      end
   end

   // square root step: two radicand bits per cycle
   assign sq_t     = {srem_ff, rad_ff[49:48]};
   assign sq_trial = 29'({root_ff, 2'b01});

   // divider: numerator 2*m*one + len, denominator 2*len, one quotient bit per cycle
   always_comb begin
      if (final_ff) begin
         num = (42'(m_ff[ci_ff][23:0]) << (dine_pkg::OUT_SH + 1)) + 42'(root_ff);
      end else begin
         num = (42'(m_ff[ci_ff][23:0]) << (dine_pkg::PAIR_SH + 1)) + 42'(root_ff);
      end
   end
   assign dv_t   = {drem_ff, dlow_ff[17]};
   assign dv_den = {1'b0, root_ff, 1'b0};
   assign dv_ge  = (dv_t >= dv_den);
   assign q_new  = {q_ff[16:0], dv_ge};

   assign c_out_w = WCMP'(c_ff);

   // next state
   always_comb begin
      frame_width_in   = frame_width_ff;
      frame_height_in  = frame_height_ff;
      neighbor_mode_in = neighbor_mode_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      state_in  = state_ff;
      point_in  = point_ff;
      win_in    = win_ff;
      c_in      = c_ff;
      rr_in     = rr_ff;
      last_in   = last_ff;
      ring_in   = ring_ff;
      ring_ok_in = ring_ok_ff;
      n_in      = n_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      mi_in     = mi_ff;
      prod_in   = opa * opb;
      v_in      = v_ff;
      m_in      = m_ff;
      neg_in    = neg_ff;
      final_in  = final_ff;
      si_in     = si_ff;
      sq_in     = sq_ff;
      rad_in    = rad_ff;
      root_in   = root_ff;
      srem_in   = srem_ff;
      it_in     = it_ff;
      ci_in     = ci_ff;
      dstep_in  = dstep_ff;
      drem_in   = drem_ff;
      dlow_in   = dlow_ff;
      q_in      = q_ff;
      u_in      = u_ff;
      sum_in    = sum_ff;
      res_in    = res_ff;
      res_valid_in  = res_valid_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      mem_we = 1'b0;
      do_adv = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            // line store read of column k is under way
            if (req_tvalid) begin
               point_in = req_tuser ? '0 : req_tdata[PW-1:0];
               state_in = S_SHIFT;
            end
         end

         S_SHIFT: begin
            mem_we = 1'b1;
            for (int i = 0; i < 3; i++) begin
               win_in[i][0] = win_ff[i][1];
               win_in[i][1] = win_ff[i][2];
            end
            win_in[0][2] = up_rd;
            win_in[1][2] = mid_rd;
            win_in[2][2] = point_ff;
            state_in = S_IDLE;
            // end of row: the last column of the row two back is complete
            if (k_eff == '0 && row_x >= (RW+1)'(2) && row_x < h_x + (RW+1)'(2)) begin
               c_in     = CW'(eff_w - WCMP'(1));
               rr_in    = row_ff - RW'(2);
               last_in  = (row_x == h_x + (RW+1)'(1));
               state_in = S_RING;
            end else if (k_eff != '0 && row_x >= (RW+1)'(1) && row_x < h_x + (RW+1)'(1)) begin
               c_in     = k_eff - CW'(1);
               rr_in    = row_ff - RW'(1);
               last_in  = 1'b0;
               state_in = S_RING;
            end
            // advance position; after the last row, a flush row and one extra position wrap the frame
            if (row_x >= h_x + (RW+1)'(1)) begin
               col_in = '0;
               row_in = '0;
            end else if (k_w + WCMP'(1) >= eff_w) begin
               col_in = '0;
               row_in = row_ff + RW'(1);
            end else begin
               col_in = k_eff + CW'(1);
            end
         end

         S_RING: begin
            for (int j = 0; j < 8; j++) begin
               ring_in[j] = ring_pt[j];
            end
            ring_ok_in = ring_pt_ok;
            n_in = '0;
            for (int i = 0; i < 3; i++) begin
               sum_in[i] = '0;
            end
            if (ctr_ok) begin
               state_in = S_PAIR;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  res_in[i] = '0;
               end
               res_valid_in = 1'b0;
               state_in = S_OUT;
            end
         end

         S_PAIR: begin
            // ring position n pairs with n+1; rotate so the next pair comes to the front
            for (int i = 0; i < 3; i++) begin
               a_in[i] = (XW+1)'(signed'(ring_ff[0][i*XW +: XW]))
                         - (XW+1)'(signed'(ctr[i*XW +: XW]));
               b_in[i] = (XW+1)'(signed'(ring_ff[1][i*XW +: XW]))
                         - (XW+1)'(signed'(ctr[i*XW +: XW]));
               v_in[i] = '0;
            end
            for (int j = 0; j < 7; j++) begin
               ring_in[j]    = ring_ff[j+1];
               ring_ok_in[j] = ring_ok_ff[j+1];
            end
            ring_in[7]    = ring_ff[0];
            ring_ok_in[7] = ring_ok_ff[0];
            if (!neighbor_mode_ff) begin
               ring_in[3]    = ring_ff[0];
               ring_ok_in[3] = ring_ok_ff[0];
            end
            mi_in = '0;
            if (ring_ok_ff[0] && ring_ok_ff[1]) begin
               final_in = 1'b0;
               state_in = S_MUL;
            end else begin
               do_adv = 1'b1;
            end
         end

         S_MUL: begin
            // six products, each added in the cycle after it is registered
            if (mi_ff != 3'd0) begin
               if (pm[0]) begin
                  v_in[pm[2:1]] = v_ff[pm[2:1]] - prod_ff[42:0];
               end else begin
                  v_in[pm[2:1]] = v_ff[pm[2:1]] + prod_ff[42:0];
               end
            end
            mi_in = mi_ff + 3'd1;
            if (mi_ff == 3'd6) begin
               state_in = S_ABS;
            end
         end

         S_ABS: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = v_ff[i][42];
               m_in[i]   = v_ff[i][42] ? 43'(-v_ff[i]) : 43'(v_ff[i]);
            end
            state_in = S_MAG;
         end

         S_MAG: begin
            // bring all magnitudes below 2^24 together
            if (m_ff[0][42:24] != '0 || m_ff[1][42:24] != '0 || m_ff[2][42:24] != '0) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = m_ff[i] >> 1;
               end
            end else begin
               si_in    = '0;
               sq_in    = '0;
               state_in = S_SQ;
            end
         end

         S_SQ: begin
            si_in = si_ff + 2'd1;
            if (si_ff != 2'd0) begin
               sq_in = sq_ff + 50'(prod_ff[47:0]);
            end
            if (si_ff == 2'd3) begin
               rad_in   = sq_ff + 50'(prod_ff[47:0]);
               root_in  = '0;
               srem_in  = '0;
               it_in    = '0;
               state_in = S_SQRT;
            end
         end

         S_SQRT: begin
            rad_in = rad_ff << 2;
            if (sq_t >= sq_trial) begin
               srem_in = 27'(sq_t - sq_trial);
               root_in = {root_ff[23:0], 1'b1};
            end else begin
               srem_in = sq_t[26:0];
               root_in = {root_ff[23:0], 1'b0};
            end
            it_in = it_ff + 5'd1;
            if (it_ff == 5'd24) begin
               if (root_in == '0) begin
                  // zero length: the pair adds nothing, the sum gives no normal
                  if (final_ff) begin
                     for (int i = 0; i < 3; i++) begin
                        res_in[i] = '0;
                     end
                     res_valid_in = 1'b0;
                     state_in = S_OUT;
                  end else begin
                     do_adv = 1'b1;
                  end
               end else begin
                  ci_in    = '0;
                  dstep_in = '0;
                  state_in = S_DIV;
               end
            end
         end

         S_DIV: begin
            if (dstep_ff == 5'd0) begin
               drem_in  = 26'(num[41:18]);
               dlow_in  = num[17:0];
               q_in     = '0;
               dstep_in = 5'd1;
            end else begin
               drem_in  = dv_ge ? 26'(dv_t - dv_den) : dv_t[25:0];
               dlow_in  = dlow_ff << 1;
               q_in     = q_new;
               dstep_in = dstep_ff + 5'd1;
               if (dstep_ff == 5'd18) begin
                  u_in[ci_ff] = neg_ff[ci_ff] ? -signed'(q_new) : signed'(q_new);
                  dstep_in = '0;
                  ci_in    = ci_ff + 2'd1;
                  if (ci_ff == 2'd2) begin
                     state_in = S_ACC;
                  end
               end
            end
         end

         S_ACC: begin
            if (final_ff) begin
               for (int i = 0; i < 3; i++) begin
                  res_in[i] = u_ff[i][dine_pkg::NORMAL_W-1:0];
               end
               res_valid_in = 1'b1;
               state_in = S_OUT;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  sum_in[i] = sum_ff[i] + 21'(u_ff[i]);
               end
               do_adv = 1'b1;
            end
         end

         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {4'b0, rr_ff[dine_pkg::PIX_W-1:0],
                                c_out_w[dine_pkg::PIX_W-1:0], res_ff[2], res_ff[1], res_ff[0]};
               rsp_tuser_in  = res_valid_ff;
               rsp_tlast_in  = last_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // next ring pair, or normalize the sum (including the pair just added) after the last one
      if (do_adv) begin
         if (n_ff == ring_last) begin
            for (int i = 0; i < 3; i++) begin
               v_in[i] = 43'(sum_in[i]);
            end
            final_in = 1'b1;
            state_in = S_ABS;
         end else begin
            n_in     = n_ff + 3'd1;
            state_in = S_PAIR;
         end
      end

      // register writes; geometry writes restart the frame
      if (csr_wr) begin
         case (csr_idx)
            dine_pkg::REG_FRAME_WIDTH: begin
               frame_width_in = csr_pwdata[dine_pkg::CFG_W-1:0];
               col_in = '0;
               row_in = '0;
            end
            dine_pkg::REG_FRAME_HEIGHT: begin
               frame_height_in = csr_pwdata[dine_pkg::CFG_W-1:0];
               col_in = '0;
               row_in = '0;
            end
            dine_pkg::REG_NEIGHBOR_MODE: begin
               neighbor_mode_in = csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= dine_pkg::FRAME_WIDTH_RST;
         frame_height_ff  <= dine_pkg::FRAME_HEIGHT_RST;
         neighbor_mode_ff <= dine_pkg::NEIGHBOR_MODE_RST;
         col_ff        <= '0;
         row_ff        <= '0;
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         frame_width_ff   <= frame_width_in;
         frame_height_ff  <= frame_height_in;
         neighbor_mode_ff <= neighbor_mode_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         win_ff        <= win_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      point_ff     <= point_in;
      c_ff         <= c_in;
      rr_ff        <= rr_in;
      last_ff      <= last_in;
      ring_ff      <= ring_in;
      ring_ok_ff   <= ring_ok_in;
      n_ff         <= n_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      mi_ff        <= mi_in;
      prod_ff      <= prod_in;
      v_ff         <= v_in;
      m_ff         <= m_in;
      neg_ff       <= neg_in;
      final_ff     <= final_in;
      si_ff        <= si_in;
      sq_ff        <= sq_in;
      rad_ff       <= rad_in;
      root_ff      <= root_in;
      srem_ff      <= srem_in;
      it_ff        <= it_in;
      ci_ff        <= ci_in;
      dstep_ff     <= dstep_in;
      drem_ff      <= drem_in;
      dlow_ff      <= dlow_in;
      q_ff         <= q_in;
      u_ff         <= u_in;
      sum_ff       <= sum_in;
      res_ff       <= res_in;
      res_valid_ff <= res_valid_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef SYNTHESIS
   // an accepted request always goes straight to the window shift
   a_accept_shift: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_SHIFT))
      else $error("accepted request did not reach the window shift");

   // a result appears only from the output hand-off state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output hand-off");

   // the row position never runs past the flush position
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_x <= h_x + (RW+1)'(1))
      else $error("row position beyond the frame flush position");
`endif

endmodule

FILE: rtl/dine_ram.sv
// generic simple dual port ram with registered read
module dine_ram #(
   parameter int DATA_W = 60,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
